>>> rtl/pip_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and request types for the point-in-polygon tester.
package pip_pkg;

	// Store and coordinate sizing
	localparam int MAX_VERTICES = 64;
	localparam int COORD_BITS   = 12;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int VCNT_W       = VIDX_W + 1;
	localparam int DIFF_W       = COORD_BITS + 1;
	localparam int PROD_W       = 2 * DIFF_W;
	localparam int ACC_W        = PROD_W + 2;
	localparam int WIND_W       = VCNT_W + 1;

	// Stream widths
	localparam int ACTION_W   = 2;
	localparam int IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = 8;

	// Action codes carried in tuser
	localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_TEST   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

	// Register file
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-3:0] REG_FILL_RULE = 1'b0;

	// Fill rules
	localparam logic RULE_EVEN_ODD = 1'b0;
	localparam logic RULE_NONZERO  = 1'b1;

	// Vertex store access: one write and one read address per cycle
	typedef struct packed {
		logic                         we;
		logic [VIDX_W-1:0]            waddr;
		logic signed [COORD_BITS-1:0] wx;
		logic signed [COORD_BITS-1:0] wy;
		logic [VIDX_W-1:0]            raddr;
	} vs_req_t;

	// Multiply-accumulate command
	typedef struct packed {
		logic                     en;
		logic                     load;
		logic                     sub;
		logic signed [DIFF_W-1:0] a;
		logic signed [DIFF_W-1:0] b;
	} mac_req_t;

endpackage

>>> rtl/pip_vstore.sv
`timescale 1ns / 1ps
// Vertex store: single-port-write, registered-read memory of polygon vertices.
module pip_vstore
	import pip_pkg::*;
(
	input  logic                         clk,
	input  vs_req_t                      req,
	output logic signed [COORD_BITS-1:0] rd_x_q,
	output logic signed [COORD_BITS-1:0] rd_y_q
);

	logic [2*COORD_BITS-1:0] mem [MAX_VERTICES];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= {req.wy, req.wx};
		end
		{rd_y_q, rd_x_q} <= mem[req.raddr];
	end

endmodule

>>> rtl/pip_mac.sv
`timescale 1ns / 1ps
// Shared signed multiply-accumulate unit used for cross products and squared lengths.
module pip_mac
	import pip_pkg::*;
(
	input  logic                    clk,
	input  mac_req_t                req,
	output logic signed [ACC_W-1:0] acc_q
);

	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  prod_x;
	logic signed [ACC_W-1:0]  base;

	// one 13x13 product per cycle
	assign prod   = req.a * req.b;
	assign prod_x = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
	assign base   = req.load ? '0 : acc_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			acc_q <= req.sub ? (base - prod_x) : (base + prod_x);
		end
	end

endmodule

>>> rtl/pip_seq.sv
`timescale 1ns / 1ps
// Sequencer: item decode, vertex count, edge walk and result register.
module pip_seq
	import pip_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ACTION_W-1:0]          action,
	input  logic signed [COORD_BITS-1:0] x_coord,
	input  logic signed [COORD_BITS-1:0] y_coord,
	input  logic                         fill_rule,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic                         inside_res,
	output logic                         vertices_dropped,
	output vs_req_t                      vs_req,
	input  logic signed [COORD_BITS-1:0] rd_x,
	input  logic signed [COORD_BITS-1:0] rd_y,
	output mac_req_t                     mac_req,
	input  logic signed [ACC_W-1:0]      acc
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_FIRST  = 4'd1;
	localparam logic [3:0] S_PRIME  = 4'd2;
	localparam logic [3:0] S_FETCH  = 4'd3;
	localparam logic [3:0] S_MUL1   = 4'd4;
	localparam logic [3:0] S_MUL2   = 4'd5;
	localparam logic [3:0] S_DECIDE = 4'd6;
	localparam logic [3:0] S_SQ1    = 4'd7;
	localparam logic [3:0] S_SQ2    = 4'd8;
	localparam logic [3:0] S_SQ3    = 4'd9;
	localparam logic [3:0] S_SQ4    = 4'd10;
	localparam logic [3:0] S_LEN    = 4'd11;
	localparam logic [3:0] S_DONE   = 4'd12;

	function automatic logic signed [DIFF_W-1:0] sx(input logic signed [COORD_BITS-1:0] v);
		return {v[COORD_BITS-1], v};
	endfunction

	logic [3:0]                   state_q;
	logic [VCNT_W-1:0]            count_q;
	logic                         ovf_q;
	logic signed [COORD_BITS-1:0] px_q, py_q, ox_q, oy_q;
	logic signed [DIFF_W-1:0]     ex_q, ey_q, qx_q, qy_q;
	logic [VIDX_W-1:0]            nxt_q, edge_q;
	logic signed [WIND_W-1:0]     wind_q;
	logic                         par_q, inside_q;
	logic                         res_valid_q, res_inside_q, res_drop_q;

	logic                         accept, full, last_edge;
	logic [VIDX_W-1:0]            last_idx;
	logic                         s_pos, s_neg, s_zero;
	logic                         qy_pos, qy_nonneg, qy_gt_ey, qy_lt_ey;
	logic                         opp_x, opp_y, decide;
	logic                         up, down, crossing, collinear_chk;
	logic signed [WIND_W-1:0]     wind_nx;
	logic                         par_nx, fin_inside;

	assign in_ready         = (state_q == S_IDLE);
	assign accept           = in_valid && in_ready;
	assign full             = (count_q == VCNT_W'(MAX_VERTICES));
	assign last_idx         = VIDX_W'(count_q - 1'b1);
	assign last_edge        = (edge_q == last_idx);
	assign res_valid        = res_valid_q;
	assign inside_res       = res_inside_q;
	assign vertices_dropped = res_drop_q;

	// edge classification from the cross product held in the accumulator
	assign s_zero    = (acc == '0);
	assign s_neg     = acc[ACC_W-1];
	assign s_pos     = !s_neg && !s_zero;
	assign qy_pos    = (qy_q > 0);
	assign qy_nonneg = !qy_q[DIFF_W-1];
	assign qy_gt_ey  = (qy_q > ey_q);
	assign qy_lt_ey  = (qy_q < ey_q);
	assign opp_x     = (ex_q != '0) && (qx_q != '0) && (ex_q[DIFF_W-1] != qx_q[DIFF_W-1]);
	assign opp_y     = (ey_q != '0) && (qy_q != '0) && (ey_q[DIFF_W-1] != qy_q[DIFF_W-1]);
	assign decide    = (state_q == S_DECIDE);

	// upward: origin at or below the point, end above; downward the reverse
	assign up       = decide && qy_nonneg && qy_lt_ey && s_pos;
	assign down     = decide && !qy_nonneg && !qy_lt_ey && s_neg;
	assign crossing = decide && ((s_pos && qy_pos && !qy_gt_ey) || (s_neg && qy_gt_ey && !qy_pos));
	assign collinear_chk = (fill_rule == RULE_EVEN_ODD) && s_zero && !opp_x && !opp_y;

	assign wind_nx    = wind_q + WIND_W'(up) - WIND_W'(down);
	assign par_nx     = par_q ^ crossing;
	assign fin_inside = (fill_rule == RULE_NONZERO) ? (wind_nx != '0) : par_nx;

	// store requests
	always_comb begin
		vs_req.we    = accept && (action == ACT_APPEND) && !full;
		vs_req.waddr = count_q[VIDX_W-1:0];
		vs_req.wx    = x_coord;
		vs_req.wy    = y_coord;
		vs_req.raddr = nxt_q;
	end

	// operand selection for the shared multiply-accumulate
	always_comb begin
		mac_req = '0;
		unique case (state_q)
			S_MUL1: begin
				mac_req = '{en: 1'b1, load: 1'b1, sub: 1'b0, a: ex_q, b: qy_q};
			end
			S_MUL2: begin
				mac_req = '{en: 1'b1, load: 1'b0, sub: 1'b1, a: qx_q, b: ey_q};
			end
			S_SQ1: begin
				mac_req = '{en: 1'b1, load: 1'b1, sub: 1'b0, a: ex_q, b: ex_q};
			end
			S_SQ2: begin
				mac_req = '{en: 1'b1, load: 1'b0, sub: 1'b0, a: ey_q, b: ey_q};
			end
			S_SQ3: begin
				mac_req = '{en: 1'b1, load: 1'b0, sub: 1'b1, a: qx_q, b: qx_q};
			end
			S_SQ4: begin
				mac_req = '{en: 1'b1, load: 1'b0, sub: 1'b1, a: qy_q, b: qy_q};
			end
			default: begin
				mac_req = '0;
			end
		endcase
	end

	// edge-walk datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				px_q   <= x_coord;
				py_q   <= y_coord;
				wind_q <= '0;
				par_q  <= 1'b0;
				edge_q <= '0;
			end
			S_FIRST: begin
				ox_q <= rd_x;
				oy_q <= rd_y;
			end
			S_FETCH: begin
				ex_q <= sx(rd_x) - sx(ox_q);
				ey_q <= sx(rd_y) - sx(oy_q);
				qx_q <= sx(px_q) - sx(ox_q);
				qy_q <= sx(py_q) - sx(oy_q);
				ox_q <= rd_x;
				oy_q <= rd_y;
			end
			S_DECIDE: begin
				wind_q <= wind_nx;
				par_q  <= par_nx;
				if (!collinear_chk) begin
					edge_q <= edge_q + 1'b1;
				end
			end
			S_LEN: begin
				edge_q <= edge_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sequencer, vertex count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			nxt_q        <= '0;
			inside_q     <= 1'b0;
			res_valid_q  <= 1'b0;
			res_inside_q <= 1'b0;
			res_drop_q   <= 1'b0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					nxt_q <= '0;
					if (accept) begin
						case (action)
							ACT_APPEND: begin
								if (full) begin
									ovf_q <= 1'b1;
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
							ACT_CLEAR: begin
								count_q <= '0;
								ovf_q   <= 1'b0;
							end
							ACT_TEST: begin
								inside_q <= 1'b0;
								state_q  <= (count_q == '0) ? S_DONE : S_FIRST;
							end
							default: begin
							end
						endcase
					end
				end
				S_FIRST: begin
					nxt_q   <= (last_idx == '0) ? '0 : VIDX_W'(1);
					state_q <= S_PRIME;
				end
				S_PRIME: begin
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					nxt_q   <= (nxt_q == last_idx) ? '0 : nxt_q + 1'b1;
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (collinear_chk) begin
						state_q <= S_SQ1;
					end else if (last_edge) begin
						inside_q <= fin_inside;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_FETCH;
					end
				end
				S_SQ1: begin
					state_q <= S_SQ2;
				end
				S_SQ2: begin
					state_q <= S_SQ3;
				end
				S_SQ3: begin
					state_q <= S_SQ4;
				end
				S_SQ4: begin
					state_q <= S_LEN;
				end
				S_LEN: begin
					// point within the segment: on the boundary, so inside
					if (!acc[ACC_W-1]) begin
						inside_q <= 1'b1;
						state_q  <= S_DONE;
					end else if (last_edge) begin
						inside_q <= fin_inside;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_FETCH;
					end
				end
				S_DONE: begin
					// read port back on the first vertex for a test taken straight after
					nxt_q <= '0;
					if (!res_valid_q) begin
						res_valid_q  <= 1'b1;
						res_inside_q <= inside_q;
						res_drop_q   <= ovf_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/point_in_polygon_tester.sv
`timescale 1ns / 1ps
// Point-in-polygon tester: takes one item at a time on s_t*; an append or clear is done
// on its transfer. A test walks the edges of the polygon through one shared multiplier
// in fetch, multiply and decide states per edge, plus squaring states and a length check
// under the even-odd rule for an edge in line with the point (unless the point lies
// behind its start vertex); a point found on an edge ends the walk early. From the
// done state, ready returns and the result appears on m_t* in that same cycle. The result
// register lets the next item be taken while a result waits; a test taken then keeps the
// block busy until that waiting result has been taken. fill_rule (byte address 0) selects
// even-odd with boundary inside (0) or non-zero (1).
module point_in_polygon_tester
	import pip_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // x_coord [11:0], y_coord [23:12]
	input  logic [ACTION_W-1:0]   s_tuser,   // action [1:0]
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // inside_res [0], vertices_dropped [1], zeros
	// register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_AW-1:0]     paddr,
	input  logic [APB_DW-1:0]     pwdata,
	output logic [APB_DW-1:0]     prdata,
	output logic                  pready
);

	logic                         fill_rule_q;
	logic                         inside_res, vertices_dropped;
	logic signed [COORD_BITS-1:0] rd_x, rd_y;
	logic signed [ACC_W-1:0]      acc;
	vs_req_t                      vs_req;
	mac_req_t                     mac_req;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr[APB_AW-1:2] == REG_FILL_RULE) ? APB_DW'(fill_rule_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_rule_q <= RULE_EVEN_ODD;
		end else if (psel && penable && pwrite && pready
			&& (paddr[APB_AW-1:2] == REG_FILL_RULE)) begin
			fill_rule_q <= pwdata[0];
		end
	end

	assign m_tdata = {(OUT_DATA_W-2)'(0), vertices_dropped, inside_res};

	pip_seq u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (s_tvalid),
		.in_ready         (s_tready),
		.action           (s_tuser),
		.x_coord          (s_tdata[COORD_BITS-1:0]),
		.y_coord          (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.fill_rule        (fill_rule_q),
		.res_valid        (m_tvalid),
		.res_ready        (m_tready),
		.inside_res       (inside_res),
		.vertices_dropped (vertices_dropped),
		.vs_req           (vs_req),
		.rd_x             (rd_x),
		.rd_y             (rd_y),
		.mac_req          (mac_req),
		.acc              (acc)
	);

	pip_vstore u_vstore (
		.clk    (clk),
		.req    (vs_req),
		.rd_x_q (rd_x),
		.rd_y_q (rd_y)
	);

	pip_mac u_mac (
		.clk   (clk),
		.req   (mac_req),
		.acc_q (acc)
	);

endmodule

>>> rtl/pip_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the point-in-polygon tester, bound to the top level.
module pip_checker
	import pip_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [ACTION_W-1:0]   s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a test transfer makes the block busy
	a_test_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == ACT_TEST) |=> !s_tready)
		else $error("input taken during a test");

	// a result is only raised out of the busy phase of a test
	a_res_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without a test");

	// append, clear and unused codes give no result
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser != ACT_TEST) && !m_tvalid |=> !m_tvalid)
		else $error("result after a non-test transfer");

endmodule

bind point_in_polygon_tester pip_checker u_pip_checker (.*);

>>> tb/tb_point_in_polygon_tester.sv
`timescale 1ns / 1ps
// Self-checking testbench for the point-in-polygon tester: directed table, then random polygons.
module tb_point_in_polygon_tester;
	import pip_pkg::*;

	localparam int CMIN           = -(1 << (COORD_BITS - 1));
	localparam int CMAX           = (1 << (COORD_BITS - 1)) - 1;
	localparam int ITEM_TARGET    = 1150;
	localparam int IDLE_LIMIT     = 4000;
	localparam int SQUEEZE_CYCLES = 300;
	localparam int SETTLE_CYCLES  = 16;
	localparam int N_DIRECTED     = 24;

	// spare action code, ignored by the block
	localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
	localparam logic [APB_AW-1:0]   RULE_ADDR = {REG_FILL_RULE, 2'b00};

	typedef enum logic {STEP_ITEM, STEP_RULE} step_kind_t;

	// one row of the directed table; fixed rows carry their answer
	typedef struct {
		step_kind_t          kind;
		logic [ACTION_W-1:0] act;
		int                  x;
		int                  y;
		logic                fixed;
		logic                in_poly;
		logic                dropped;
	} step_t;

	typedef struct {
		logic fixed;
		logic in_poly;
		logic dropped;
	} answer_t;

	typedef struct {
		logic in_poly;
		logic dropped;
	} verdict_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // x_coord [11:0], y_coord [23:12]
	logic [ACTION_W-1:0]   s_tuser;   // action [1:0]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // inside_res [0], vertices_dropped [1], zeros
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_AW-1:0]     paddr;
	logic [APB_DW-1:0]     pwdata;
	logic [APB_DW-1:0]     prdata;
	logic                  pready;

	// shadow of the block: vertex store, count, overflow and rule
	logic signed [COORD_BITS-1:0] poly_x [MAX_VERTICES];
	logic signed [COORD_BITS-1:0] poly_y [MAX_VERTICES];
	int   poly_n    = 0;
	logic poly_drop = 1'b0;
	logic rule_now  = RULE_EVEN_ODD;

	verdict_t verdict_q [$];
	answer_t  answer_q  [$];

	int   err_cnt      = 0;
	int   items_sent   = 0;
	int   results_seen = 0;
	int   drop_seen    = 0;
	int   inside_seen  = 0;
	int   rule_writes  = 0;
	logic calm         = 1'b0;
	logic squeeze_req  = 1'b0;
	int   sink_hold    = 0;

	step_t directed [N_DIRECTED] = '{
		'{STEP_ITEM, ACT_TEST,   0,     0,     1'b1, 1'b0, 1'b0},
		'{STEP_ITEM, ACT_SPARE,  -2048, 2047,  1'b0, 1'b0, 1'b0},
		'{STEP_ITEM, ACT_TEST,   5,     -7,    1'b1, 1'b0, 1'b0},
		'{STEP_ITEM, ACT_APPEND, -2048, -2048, 1'b0, 1'b0, 1'b0},
		'{STEP_ITEM, ACT_TEST,   -2048, -2048, 1'b1, 1'b1, 1'b0},
		'{STEP_ITEM, ACT_TEST,   2047,  2047,  1'b1, 1'b0, 1'b0},
		'{STEP_ITEM, ACT_APPEND, 2047,  2047,  1'b0, 1'b0, 1'b0},
		'{STEP_ITEM, ACT_TEST,   0,     0,     1'b0, 1'b0, 1'b0},
		'{STEP_ITEM, ACT_TEST,   1,     0,     1'b0, 1'b0, 1'b0},
		'{STEP_ITEM, ACT_APPEND, 2047,  -2048, 1'b0, 1'b0, 1'b0},
		'{STEP_ITEM, ACT_TEST,   1000,  -1000, 1'b0, 1'b0, 1'b0},
		'{STEP_ITEM, ACT_TEST,   -2048, 2047,  1'b0, 1'b0, 1'b0},
		'{STEP_ITEM, ACT_CLEAR,  0,     0,     1'b0, 1'b0, 1'b0},
		'{STEP_ITEM, ACT_TEST,   0,     0,     1'b1, 1'b0, 1'b0},
		'{STEP_ITEM, ACT_APPEND, -2048, -2048, 1'b0, 1'b0, 1'b0},
		'{STEP_ITEM, ACT_APPEND, 2047,  -2048, 1'b0, 1'b0, 1'b0},
		'{STEP_ITEM, ACT_APPEND, 2047,  2047,  1'b0, 1'b0, 1'b0},
		'{STEP_ITEM, ACT_APPEND, -2048, 2047,  1'b0, 1'b0, 1'b0},
		'{STEP_ITEM, ACT_TEST,   0,     0,     1'b0, 1'b0, 1'b0},
		'{STEP_ITEM, ACT_TEST,   2047,  0,     1'b0, 1'b0, 1'b0},
		'{STEP_RULE, ACT_TEST,   0,     0,     1'b0, 1'b0, 1'b0},
		'{STEP_ITEM, ACT_TEST,   0,     0,     1'b0, 1'b0, 1'b0},
		'{STEP_ITEM, ACT_TEST,   2047,  2047,  1'b0, 1'b0, 1'b0},
		'{STEP_ITEM, ACT_TEST,   -2048, 0,     1'b0, 1'b0, 1'b0}
	};

	point_in_polygon_tester u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// even-odd walk; a point on any edge is inside at once
	function automatic logic even_odd_inside(longint px, longint py);
		logic   parity;
		logic   crossed;
		int     j;
		longint ox, oy, dx, dy, ex, ey, qx, qy, s;
		parity = 1'b0;
		for (int i = 0; i < poly_n; i++) begin
			j  = (i + 1 == poly_n) ? 0 : i + 1;
			ox = longint'(poly_x[i]);
			oy = longint'(poly_y[i]);
			dx = longint'(poly_x[j]);
			dy = longint'(poly_y[j]);
			ex = dx - ox;
			ey = dy - oy;
			qx = px - ox;
			qy = py - oy;
			s  = ex * qy - qx * ey;
			crossed = 1'b0;
			if (s > 0)
				crossed = (py > oy) && (py <= dy);
			else if (s < 0)
				crossed = (py > dy) && (py <= oy);
			else if (ex * qx >= 0 && ey * qy >= 0 && ex * ex + ey * ey >= qx * qx + qy * qy)
				return 1'b1;
			if (crossed)
				parity = ~parity;
		end
		return parity;
	endfunction

	// non-zero winding: upward crossings with the point on the left count +1
	function automatic logic winding_inside(longint px, longint py);
		int     wind;
		int     j;
		longint x1, y1, x2, y2, side;
		wind = 0;
		for (int i = 0; i < poly_n; i++) begin
			j    = (i + 1 == poly_n) ? 0 : i + 1;
			x1   = longint'(poly_x[i]);
			y1   = longint'(poly_y[i]);
			x2   = longint'(poly_x[j]);
			y2   = longint'(poly_y[j]);
			side = (x2 - x1) * (py - y1) - (y2 - y1) * (px - x1);
			if (y1 <= py) begin
				if (y2 > py && side > 0)
					wind++;
			end else if (y2 <= py && side < 0) begin
				wind--;
			end
		end
		return wind != 0;
	endfunction

	// input transfers update the shadow state; result transfers are checked
	always @(posedge clk) begin : scoreboard
		logic signed [COORD_BITS-1:0] ix, iy;
		answer_t  pin;
		verdict_t v;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				ix = s_tdata[COORD_BITS-1:0];
				iy = s_tdata[2*COORD_BITS-1:COORD_BITS];
				case (s_tuser)
					ACT_APPEND: begin
						if (poly_n < MAX_VERTICES) begin
							poly_x[poly_n] = ix;
							poly_y[poly_n] = iy;
							poly_n++;
						end else begin
							poly_drop = 1'b1;
						end
					end
					ACT_CLEAR: begin
						poly_n    = 0;
						poly_drop = 1'b0;
					end
					ACT_TEST: begin
						pin = answer_q.pop_front();
						if (pin.fixed) begin
							v.in_poly = pin.in_poly;
							v.dropped = pin.dropped;
						end else begin
							v.in_poly = (rule_now == RULE_NONZERO) ? winding_inside(ix, iy)
								: even_odd_inside(ix, iy);
							v.dropped = poly_drop;
						end
						verdict_q.insert(verdict_q.size(), v);
					end
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				drop_seen   += m_tdata[1];
				inside_seen += m_tdata[0];
				if (verdict_q.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result, expected none, got %02h", $time, m_tdata);
				end else begin
					v = verdict_q.pop_front();
					if (m_tdata[0] !== v.in_poly) begin
						err_cnt++;
						$display("%0t: inside_res expected %0b got %0b", $time, v.in_poly,
							m_tdata[0]);
					end
					if (m_tdata[1] !== v.dropped) begin
						err_cnt++;
						$display("%0t: vertices_dropped expected %0b got %0b", $time,
							v.dropped, m_tdata[1]);
					end
				end
			end
		end
	end

	// result sink: random back-pressure, one long hold-off on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				sink_hold   = SQUEEZE_CYCLES;
				m_tready <= 1'b0;
			end else if (m_tready && m_tvalid) begin
				sink_hold = calm ? 0 : $urandom_range(0, 7);
				if (sink_hold != 0)
					m_tready <= 1'b0;
			end else if (!m_tready) begin
				if (sink_hold > 0)
					sink_hold--;
				if (sink_hold == 0)
					m_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin : watchdog
		int quiet;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
			|| (psel && penable && pready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet);
				$display("tb_point_in_polygon_tester: done, errors");
				$finish;
			end
		end
	end

	// offer one item and wait for its transfer
	task automatic offer_item(input logic [ACTION_W-1:0] act, input int x, input int y,
		input logic fixed = 1'b0, input logic in_poly = 1'b0, input logic dropped = 1'b0);
		int gap;
		answer_t pin;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (act == ACT_TEST) begin
			pin.fixed   = fixed;
			pin.in_poly = in_poly;
			pin.dropped = dropped;
			answer_q.insert(answer_q.size(), pin);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= IN_DATA_W'({y[COORD_BITS-1:0], x[COORD_BITS-1:0]});
		do @(posedge clk); while (!s_tready);
		if (act != ACT_SPARE)
			items_sent++;
	endtask

	// wait until the block has nothing left to deliver
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write fill_rule, then read it back
	task automatic write_rule(input logic rule);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= RULE_ADDR;
		pwdata  <= {{(APB_DW - 1){1'b0}}, rule};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rule_now = rule;
		rule_writes++;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {{(APB_DW - 1){1'b0}}, rule}) begin
			err_cnt++;
			$display("%0t: fill_rule readback expected %0h got %0h", $time, rule, prdata);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// random coordinate around a centre, clipped to the field range
	function automatic int near(int c, int r);
		int v;
		v = c + int'($urandom_range(0, 2 * r)) - r;
		if (v < CMIN)
			v = CMIN;
		if (v > CMAX)
			v = CMAX;
		return v;
	endfunction

	function automatic int any_coord();
		return int'($urandom_range(0, CMAX - CMIN)) + CMIN;
	endfunction

	// clear (mostly), then append a polygon of random size and spread
	task automatic load_polygon(output int cx, output int cy, output int r);
		int pick, n;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			n = $urandom_range(3, 10);
		else if (pick == 6)
			n = $urandom_range(1, 2);
		else if (pick == 7)
			n = $urandom_range(11, 40);
		else if (pick == 8)
			n = $urandom_range(60, 70);
		else
			n = $urandom_range(3, 6);
		pick = $urandom_range(0, 9);
		r  = (pick < 5) ? $urandom_range(1, 8) : (pick < 8) ? $urandom_range(9, 200) : 4096;
		cx = any_coord();
		cy = any_coord();
		if ($urandom_range(0, 9) != 0)
			offer_item(ACT_CLEAR, any_coord(), any_coord());
		repeat (n) offer_item(ACT_APPEND, near(cx, r), near(cy, r));
	endtask

	// test points on vertices, edge midpoints, nearby and anywhere
	task automatic probe_polygon(input int cx, input int cy, input int r);
		int pick, i, j, px, py;
		repeat ($urandom_range(3, 8)) begin
			pick = $urandom_range(0, 9);
			px   = any_coord();
			py   = any_coord();
			if (poly_n > 0 && pick < 3) begin
				i  = $urandom_range(0, poly_n - 1);
				px = poly_x[i];
				py = poly_y[i];
			end else if (poly_n > 0 && pick < 5) begin
				i  = $urandom_range(0, poly_n - 1);
				j  = (i + 1 == poly_n) ? 0 : i + 1;
				px = (int'(poly_x[i]) + int'(poly_x[j])) >>> 1;
				py = (int'(poly_y[i]) + int'(poly_y[j])) >>> 1;
			end else if (pick < 8) begin
				px = near(cx, r);
				py = near(cy, r);
			end else if (pick == 8) begin
				px = near(cx, 0);
				py = near(cy, 0);
			end
			offer_item(ACT_TEST, px, py);
		end
	endtask

	// reset, directed table, random phases, end of run
	initial begin : stimulus
		int cx, cy, r, phase;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = ACT_APPEND;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; rule rows flip between even-odd and non-zero
		for (int k = 0; k < N_DIRECTED; k++) begin
			if (directed[k].kind == STEP_RULE) begin
				settle();
				write_rule(~rule_now);
			end else begin
				offer_item(directed[k].act, directed[k].x, directed[k].y,
					directed[k].fixed, directed[k].in_poly, directed[k].dropped);
			end
		end

		// random phases, each with its own rule and idling style
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			settle();
			write_rule(phase[0] ? RULE_EVEN_ODD : RULE_NONZERO);
			calm = ($urandom_range(0, 3) == 0);
			if (phase == 2) begin
				calm        = 1'b1;
				squeeze_req = 1'b1;
			end
			for (int p = 0; p < 6 && items_sent < ITEM_TARGET; p++) begin
				load_polygon(cx, cy, r);
				probe_polygon(cx, cy, r);
				if ($urandom_range(0, 7) == 0)
					offer_item(ACT_SPARE, any_coord(), any_coord());
				if ($urandom_range(0, 9) == 0)
					offer_item(ACT_TEST, any_coord(), any_coord());
				if ($urandom_range(0, 9) == 0)
					offer_item(ACT_APPEND, any_coord(), any_coord());
			end
			phase++;
		end

		settle();
		$display("%0d items over %0d rule settings; %0d results checked", items_sent,
			rule_writes, results_seen);
		$display("%0d answered inside, %0d flagged dropped vertices", inside_seen, drop_seen);
		if (err_cnt == 0)
			$display("tb_point_in_polygon_tester: done, clean");
		else
			$display("tb_point_in_polygon_tester: done, errors");
		$finish;
	end

endmodule
